// ----- src/accel_orientation_hysteresis_macros.svh -----
// Assertion macros shared by the orientation detector
`ifndef ACCEL_ORIENTATION_HYSTERESIS_MACROS_SVH
`define ACCEL_ORIENTATION_HYSTERESIS_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define AOH_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define AOH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/aoh_pkg.sv -----
`timescale 1ns / 1ps

package aoh_pkg;

    // Scaling: 1 g is this many counts
    localparam int ONE_G = 4096;

    localparam int THR_WIDTH            = 13;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 13'd1638;
    localparam int SAMPLE_WIDTH_DEFAULT = 16;
    localparam int POSE_WIDTH           = 3;
    localparam int NUM_POSES            = 6;
    localparam int M_TDATA_WIDTH        = 8;

    // Orientation codes
    typedef enum logic [POSE_WIDTH-1:0] {
        POSE_UNKNOWN = 3'd0,
        POSE_NEG_X   = 3'd1,
        POSE_POS_Z   = 3'd2,
        POSE_POS_Y   = 3'd3,
        POSE_NEG_Y   = 3'd4,
        POSE_NEG_Z   = 3'd5,
        POSE_POS_X   = 3'd6
    } pose_t;

    // Direction of one axis of a pose's unit vector
    typedef enum logic [1:0] {
        DIR_ZERO = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } dir_t;

    typedef struct packed {
        dir_t x;
        dir_t y;
        dir_t z;
    } pose_vec_t;

    // Unit vector of each pose
    function automatic pose_vec_t pose_vec(input pose_t pose);
        pose_vec_t v;
        v = '{x: DIR_ZERO, y: DIR_ZERO, z: DIR_ZERO};
        unique case (pose)
            POSE_NEG_X: v.x = DIR_NEG;
            POSE_POS_Z: v.z = DIR_POS;
            POSE_POS_Y: v.y = DIR_POS;
            POSE_NEG_Y: v.y = DIR_NEG;
            POSE_NEG_Z: v.z = DIR_NEG;
            POSE_POS_X: v.x = DIR_POS;
            default:    v = '{x: DIR_ZERO, y: DIR_ZERO, z: DIR_ZERO};
        endcase
        return v;
    endfunction

endpackage

// ----- src/aoh_pose_eval.sv -----
`timescale 1ns / 1ps

module aoh_pose_eval #(
    parameter int SAMPLE_WIDTH = aoh_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic signed [SAMPLE_WIDTH-1:0]    accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]    accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]    accel_z,
    input  logic [aoh_pkg::THR_WIDTH-1:0]     thr,
    input  aoh_pkg::pose_t                    pose,
    output aoh_pkg::pose_t                    pose_next
);
    import aoh_pkg::*;

    // Compare width: room for the sample, the 13-bit threshold and the 1 g offset
    localparam int CW = ((SAMPLE_WIDTH > THR_WIDTH + 1) ? SAMPLE_WIDTH : THR_WIDTH + 1) + 2;

    typedef logic signed [CW-1:0] acc_t;

    localparam acc_t ONE_G_S = acc_t'(ONE_G);

    // True when an axis has left its band around the held pose
    function automatic logic out_of_band(input dir_t d, input acc_t a,
                                         input acc_t t, input acc_t l);
        logic r;
        unique case (d)
            DIR_POS: r = (a < l);
            DIR_NEG: r = (a > -l);
            default: r = (a < -t) || (a > t);
        endcase
        return r;
    endfunction

    // True when an axis lies strictly within the limit of the target
    function automatic logic near(input dir_t d, input acc_t a, input acc_t l);
        acc_t tgt;
        acc_t diff;
        unique case (d)
            DIR_POS: tgt = ONE_G_S;
            DIR_NEG: tgt = -ONE_G_S;
            default: tgt = '0;
        endcase
        diff = (tgt > a) ? (tgt - a) : (a - tgt);
        return diff < l;
    endfunction

    acc_t                 ax;
    acc_t                 ay;
    acc_t                 az;
    acc_t                 thr_s;
    acc_t                 lim;
    pose_vec_t            held_vec;
    pose_vec_t            cand_vec;
    logic                 leave;
    logic [NUM_POSES:1]   hit;

    // Extend operands and form the match limit 1 g - thr
    assign ax    = acc_t'(accel_x);
    assign ay    = acc_t'(accel_y);
    assign az    = acc_t'(accel_z);
    assign thr_s = signed'(CW'(thr));
    assign lim   = ONE_G_S - thr_s;

    // Band test against the held pose
    assign held_vec = pose_vec(pose);
    assign leave    = out_of_band(held_vec.x, ax, thr_s, lim)
                    | out_of_band(held_vec.y, ay, thr_s, lim)
                    | out_of_band(held_vec.z, az, thr_s, lim);

    // Match every candidate pose in parallel
    always_comb begin
        cand_vec = '{x: DIR_ZERO, y: DIR_ZERO, z: DIR_ZERO};
        for (int i = 1; i <= NUM_POSES; i++) begin
            cand_vec = pose_vec(pose_t'(i[POSE_WIDTH-1:0]));
            hit[i]   = near(cand_vec.x, ax, lim) & near(cand_vec.y, ay, lim)
                     & near(cand_vec.z, az, lim);
        end
    end

    // Take the lowest matching pose, else hold
    always_comb begin
        pose_next = pose;
        if (leave) begin
            for (int i = NUM_POSES; i >= 1; i--) begin
                if (hit[i]) begin
                    pose_next = pose_t'(i[POSE_WIDTH-1:0]);
                end
            end
        end
    end

endmodule

// ----- src/accel_orientation_hysteresis.sv -----
`timescale 1ns / 1ps

// Six-pose orientation detector with hysteresis. Each sample word carries
// accel_x, accel_y, accel_z (signed, 4096 counts per g) and yields one result
// word holding the orientation code (0 unknown, 1 -X, 2 +Z, 3 +Y, 4 -Y, 5 -Z,
// 6 +X). A sample sits in an input register, is compared against the held
// pose and lands in the output register once that is free; one sample per
// cycle is sustained while m_axis_tready stays high. The rate is set by the
// pose register, which feeds the compare logic and is updated in the same
// cycle. cfg_data writes the 13-bit hysteresis threshold (reset 1638, about
// 0.4 g); write it only while the block is idle.
module accel_orientation_hysteresis #(
    parameter int SAMPLE_WIDTH = aoh_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Sample channel
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [SW-1:0] accel_x, [2SW-1:SW] accel_y, [3SW-1:2SW] accel_z, zero pad above
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // Result channel
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [2:0] orientation_code, zero pad above
    output logic [aoh_pkg::M_TDATA_WIDTH-1:0]      m_axis_tdata,
    // Threshold write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [aoh_pkg::THR_WIDTH-1:0]          cfg_data
);
    import aoh_pkg::*;

`include "accel_orientation_hysteresis_macros.svh"

    logic [THR_WIDTH-1:0]           thr_reg;
    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] ax_reg;
    logic signed [SAMPLE_WIDTH-1:0] ay_reg;
    logic signed [SAMPLE_WIDTH-1:0] az_reg;
    pose_t                          pose_reg;
    pose_t                          pose_next;
    logic                           m_valid_reg;
    pose_t                          m_code_reg;
    logic                           out_free;
    logic                           fire;
    logic                           s_accept;

    // Handshake: input register frees when its word moves to the output
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ax_reg <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            ay_reg <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
            az_reg <= s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
        end
    end

    // Pose compare
    aoh_pose_eval #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_pose_eval (
        .accel_x   (ax_reg),
        .accel_y   (ay_reg),
        .accel_z   (az_reg),
        .thr       (thr_reg),
        .pose      (pose_reg),
        .pose_next (pose_next)
    );

    // Advance held pose and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pose_reg    <= POSE_UNKNOWN;
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            pose_reg    <= pose_next;
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_code_reg <= pose_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_WIDTH'(m_code_reg);

    // Checks
    `AOH_ASSERT_NEXT(a_pose_only_on_fire, aclk, aresetn, !fire, $stable(pose_reg), "pose changed without a word")
    `AOH_ASSERT_NEXT(a_result_is_pose, aclk, aresetn, fire, m_valid_reg && (m_code_reg == pose_reg), "result differs from held pose")
    `AOH_ASSERT_NEXT(a_in_word_kept, aclk, aresetn, in_valid_reg && !fire, in_valid_reg, "input word dropped")
    `AOH_ASSERT_NOW(a_no_overwrite, aclk, aresetn, in_valid_reg && !fire, !s_axis_tready, "input register overwritten")

endmodule
